[sv/sidvf_pkg.sv]
// Shared types and constants for the voice mixer and state-variable filter.
// Used by every module of sid_voice_filter_mixer; depends on nothing.
`default_nettype none
package sidvf_pkg;

    localparam int OSC_W    = 12;
    localparam int ENV_W    = 8;
    localparam int CUTOFF_W = 17;
    localparam int Q_W      = 11;
    localparam int VOL_W    = 4;
    localparam int LEVEL_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Operand and product widths of the shared multiplier.
    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int VOICE_LVL_W = 14;
    localparam int VOICE_SUM_W = 16;

    localparam logic [CUTOFF_W-1:0] CUTOFF_MAX = 17'd105414;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_ENABLE = 3'd0,
        REG_ROUTE_MASK    = 3'd1,
        REG_VOICE3_OFF    = 3'd2,
        REG_MODE_SELECT   = 3'd3,
        REG_VOLUME        = 3'd4,
        REG_CUTOFF_COEFF  = 3'd5,
        REG_Q_COEFF       = 3'd6,
        REG_WAVE_ZERO     = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic                filter_enable;
        logic [3:0]          route_mask;
        logic                voice3_off;
        logic [2:0]          mode_select;
        logic [VOL_W-1:0]    volume;
        logic [CUTOFF_W-1:0] cutoff_coeff;
        logic [Q_W-1:0]      q_coeff;
        logic [OSC_W-1:0]    wave_zero;
    } cfg_t;

endpackage
`default_nettype wire

[sv/sidvf_cfg.sv]
// Configuration register file of the voice mixer and filter.
// Depends on sidvf_pkg for the register index codes and the cfg_t bundle.
`default_nettype none
module sidvf_cfg
    import sidvf_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.filter_enable <= 1'b1;
            cfg_reg.route_mask    <= '0;
            cfg_reg.voice3_off    <= 1'b0;
            cfg_reg.mode_select   <= '0;
            cfg_reg.volume        <= '0;
            cfg_reg.cutoff_coeff  <= '0;
            cfg_reg.q_coeff       <= 11'd1448;
            cfg_reg.wave_zero     <= 12'd2048;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                REG_FILTER_ENABLE: cfg_reg.filter_enable <= cfg_wdata[0];
                REG_ROUTE_MASK:    cfg_reg.route_mask    <= cfg_wdata[3:0];
                REG_VOICE3_OFF:    cfg_reg.voice3_off    <= cfg_wdata[0];
                REG_MODE_SELECT:   cfg_reg.mode_select   <= cfg_wdata[2:0];
                REG_VOLUME:        cfg_reg.volume        <= cfg_wdata[VOL_W-1:0];
                REG_CUTOFF_COEFF:  cfg_reg.cutoff_coeff  <= cfg_wdata[CUTOFF_W-1:0];
                REG_Q_COEFF:       cfg_reg.q_coeff       <= cfg_wdata[Q_W-1:0];
                REG_WAVE_ZERO:     cfg_reg.wave_zero     <= cfg_wdata[OSC_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

[sv/sidvf_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on sidvf_pkg for the operand widths.
`default_nettype none
module sidvf_mul
    import sidvf_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic signed [MUL_A_W-1:0] mul_a,
    input  wire logic signed [MUL_B_W-1:0] mul_b,
    output logic signed [MUL_P_W-1:0]      mul_prod
);

    logic signed [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    end

    assign mul_prod = prod_reg;

endmodule
`default_nettype wire

[sv/sidvf_core.sv]
// Sequencer and datapath registers: voice scaling, filter update and final mix.
// Drives the shared multiplier in sidvf_mul; depends on sidvf_pkg.
`default_nettype none
module sidvf_core
    import sidvf_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire cfg_t                      cfg,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [OSC_W-1:0]          s_osc_voice1,
    input  wire logic [OSC_W-1:0]          s_osc_voice2,
    input  wire logic [OSC_W-1:0]          s_osc_voice3,
    input  wire logic [ENV_W-1:0]          s_env_voice1,
    input  wire logic [ENV_W-1:0]          s_env_voice2,
    input  wire logic [ENV_W-1:0]          s_env_voice3,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [LEVEL_W-1:0]      m_mix_sample,
    output logic signed [MUL_A_W-1:0]      mul_a,
    output logic signed [MUL_B_W-1:0]      mul_b,
    input  wire logic signed [MUL_P_W-1:0] mul_prod
);

    typedef enum logic [3:0] {
        S_IDLE, S_V1, S_V2, S_V3, S_DBP, S_DLP, S_HPQ, S_HP, S_SUM, S_MIX, S_OUT
    } state_t;

    state_t state_reg;

    logic [OSC_W-1:0] osc_reg [3];
    logic [ENV_W-1:0] env_reg [3];

    logic signed [LEVEL_W-1:0]     hp_reg, bp_reg, lp_reg;
    logic signed [VOICE_SUM_W-1:0] vi_reg, vnf_reg;
    logic signed [MUL_A_W-1:0]     sum_reg;
    logic signed [LEVEL_W-1:0]     mix_reg;
    logic                          m_valid_reg;

    logic [CUTOFF_W-1:0]           w_coeff;
    logic [1:0]                    voice_sel;
    logic [1:0]                    issue_sel;
    logic signed [OSC_W:0]         voice_diff;
    logic signed [VOICE_SUM_W-1:0] voice_lvl;
    logic                          voice_mute;
    logic                          voice_to_filter;
    logic signed [MUL_A_W-1:0]     sum_next;
    logic signed [LEVEL_W-1:0]     sat_value;
    logic                          out_free;

    assign w_coeff = (cfg.cutoff_coeff > CUTOFF_MAX) ? CUTOFF_MAX : cfg.cutoff_coeff;

    // The product of the voice issued one state earlier is consumed here.
    always_comb begin
        case (state_reg)
            S_V2:    voice_sel = 2'd0;
            S_V3:    voice_sel = 2'd1;
            S_DBP:   voice_sel = 2'd2;
            default: voice_sel = 2'd0;
        endcase
    end

    always_comb begin
        case (state_reg)
            S_V2:    issue_sel = 2'd1;
            S_V3:    issue_sel = 2'd2;
            default: issue_sel = 2'd0;
        endcase
    end

    assign voice_lvl = VOICE_SUM_W'($signed(mul_prod[VOICE_LVL_W+6:7]));
    assign voice_mute = (voice_sel == 2'd2) && cfg.voice3_off && !cfg.route_mask[2];
    assign voice_to_filter = cfg.filter_enable && cfg.route_mask[voice_sel];

    // Operand selection for the shared multiplier.
    always_comb begin
        voice_diff = '0;
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_V1, S_V2, S_V3: begin
                voice_diff = $signed({1'b0, osc_reg[issue_sel]})
                           - $signed({1'b0, cfg.wave_zero});
                mul_a = MUL_A_W'(voice_diff);
                mul_b = MUL_B_W'(env_reg[issue_sel]);
            end
            S_DBP: begin
                mul_a = MUL_A_W'(hp_reg);
                mul_b = MUL_B_W'(w_coeff);
            end
            S_DLP: begin
                mul_a = MUL_A_W'(bp_reg);
                mul_b = MUL_B_W'(w_coeff);
            end
            S_HPQ: begin
                mul_a = MUL_A_W'(bp_reg);
                mul_b = MUL_B_W'(cfg.q_coeff);
            end
            // The volume product is reissued while the result waits for the output.
            S_MIX, S_OUT: begin
                mul_a = sum_reg;
                mul_b = MUL_B_W'(cfg.volume);
            end
            default: ;
        endcase
    end

    assign sum_next = MUL_A_W'(vnf_reg)
                    + (cfg.mode_select[0] ? MUL_A_W'(lp_reg) : '0)
                    + (cfg.mode_select[1] ? MUL_A_W'(bp_reg) : '0)
                    + (cfg.mode_select[2] ? MUL_A_W'(hp_reg) : '0);

    // Saturate the final product to the signed 32-bit range.
    always_comb begin
        if (&mul_prod[MUL_P_W-1:LEVEL_W-1] || ~|mul_prod[MUL_P_W-1:LEVEL_W-1]) begin
            sat_value = mul_prod[LEVEL_W-1:0];
        end else if (mul_prod[MUL_P_W-1]) begin
            sat_value = {1'b1, {(LEVEL_W-1){1'b0}}};
        end else begin
            sat_value = {1'b0, {(LEVEL_W-1){1'b1}}};
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            hp_reg      <= '0;
            bp_reg      <= '0;
            lp_reg      <= '0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        osc_reg[0] <= s_osc_voice1;
                        osc_reg[1] <= s_osc_voice2;
                        osc_reg[2] <= s_osc_voice3;
                        env_reg[0] <= s_env_voice1;
                        env_reg[1] <= s_env_voice2;
                        env_reg[2] <= s_env_voice3;
                        vi_reg     <= '0;
                        vnf_reg    <= '0;
                        state_reg  <= S_V1;
                    end
                end
                S_V1: state_reg <= S_V2;
                S_V2, S_V3, S_DBP: begin
                    if (!voice_mute) begin
                        if (voice_to_filter) begin
                            vi_reg <= vi_reg + voice_lvl;
                        end else begin
                            vnf_reg <= vnf_reg + voice_lvl;
                        end
                    end
                    if (state_reg == S_V2) begin
                        state_reg <= S_V3;
                    end else if (state_reg == S_V3) begin
                        state_reg <= S_DBP;
                    end else if (!cfg.filter_enable) begin
                        hp_reg    <= '0;
                        bp_reg    <= '0;
                        lp_reg    <= '0;
                        state_reg <= S_SUM;
                    end else begin
                        state_reg <= S_DLP;
                    end
                end
                S_DLP: begin
                    bp_reg    <= bp_reg - mul_prod[LEVEL_W+19:20];
                    state_reg <= S_HPQ;
                end
                S_HPQ: begin
                    lp_reg    <= lp_reg - mul_prod[LEVEL_W+19:20];
                    state_reg <= S_HP;
                end
                S_HP: begin
                    hp_reg    <= mul_prod[LEVEL_W+9:10] - lp_reg - LEVEL_W'(vi_reg);
                    state_reg <= S_SUM;
                end
                S_SUM: begin
                    sum_reg   <= sum_next;
                    state_reg <= S_MIX;
                end
                S_MIX: state_reg <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        mix_reg     <= sat_value;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_mix_sample = mix_reg;

`ifndef SYNTH
    // Only one item is in flight: an accepted transfer closes the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item is in progress");

    // The sequencer leaves idle only on an input transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && !s_valid) |=> (state_reg == S_IDLE))
        else $error("sequencer started without an input transfer");

    // In bypass mode the filter levels are cleared before the mix is formed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SUM && !cfg.filter_enable) |->
            (hp_reg == '0 && bp_reg == '0 && lp_reg == '0))
        else $error("filter levels not cleared in bypass mode");

    // A new result appears only when the sequencer finishes an item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result raised outside the output step");
`endif

endmodule
`default_nettype wire

[sv/sid_voice_filter_mixer.sv]
// Voice mixer with 8580-style state-variable filter, one shared multiplier.
// Each input steps through the voice, filter, sum, mix and output states; bypass
// skips the filter update. One multiplier pass per voice and filter term; volume is
// reissued while the output stalls. Input waits until the result is registered.
// Reset (aresetn low, synchronous) clears the filter levels and the handshakes
// and loads the register defaults.
`default_nettype none
module sid_voice_filter_mixer
    import sidvf_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [OSC_W-1:0]      s_osc_voice1,
    input  wire logic [OSC_W-1:0]      s_osc_voice2,
    input  wire logic [OSC_W-1:0]      s_osc_voice3,
    input  wire logic [ENV_W-1:0]      s_env_voice1,
    input  wire logic [ENV_W-1:0]      s_env_voice2,
    input  wire logic [ENV_W-1:0]      s_env_voice3,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [LEVEL_W-1:0]  m_mix_sample
);

    cfg_t                      cfg;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_prod;

    sidvf_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sidvf_mul u_mul (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .mul_prod (mul_prod)
    );

    sidvf_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_osc_voice1 (s_osc_voice1),
        .s_osc_voice2 (s_osc_voice2),
        .s_osc_voice3 (s_osc_voice3),
        .s_env_voice1 (s_env_voice1),
        .s_env_voice2 (s_env_voice2),
        .s_env_voice3 (s_env_voice3),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_mix_sample (m_mix_sample),
        .mul_a        (mul_a),
        .mul_b        (mul_b),
        .mul_prod     (mul_prod)
    );

endmodule
`default_nettype wire
